// File: design/skbh_pkg.sv
`default_nettype none
package skbh_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CrcW = 32;
	localparam int unsigned HashW = 64;
	localparam int unsigned SizeW = 31;
	localparam int unsigned IndexW = 30;
	localparam int unsigned MixSteps = 8;
	localparam int unsigned QueueDepthDefault = 2;

	localparam logic [CrcW-1:0] CrcPoly = 32'hEDB88320;
	localparam logic [31:0] KnuthMult = 32'd2654435761;
	localparam logic [SizeW-1:0] TableSizeReset = 31'd256;

	typedef struct packed {
		logic valid;
		logic [CrcW-1:0] crc;
	} crc_push_t;

	function automatic logic [CrcW-1:0] crc_entry(input logic [ByteW-1:0] idx);
		logic [CrcW-1:0] v;
		v = {{(CrcW-ByteW){1'b0}}, idx};
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
		end
		return v;
	endfunction

	function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
			input logic [ByteW-1:0] b);
		return crc_entry(crc[ByteW-1:0] ^ b) ^ (crc >> 8);
	endfunction

endpackage
`default_nettype wire

// File: design/skbh_key_if.sv
`default_nettype none
interface skbh_key_if;
	logic valid;
	logic ready;
	logic [skbh_pkg::ByteW-1:0] key_byte;
	logic byte_present;
	logic last_byte;

	modport source(output valid, output key_byte, output byte_present, output last_byte,
		input ready);
	modport sink(input valid, input key_byte, input byte_present, input last_byte,
		output ready);
endinterface
`default_nettype wire

// File: design/skbh_bucket_if.sv
`default_nettype none
interface skbh_bucket_if;
	logic valid;
	logic ready;
	logic [skbh_pkg::IndexW-1:0] bucket_index;

	modport source(output valid, output bucket_index, input ready);
	modport sink(input valid, input bucket_index, output ready);
endinterface
`default_nettype wire

// File: design/skbh_front.sv
`default_nettype none
module skbh_front (
	input wire logic clk,
	input wire logic arst_n,
	skbh_key_if.sink key,
	input wire logic q_full,
	output skbh_pkg::crc_push_t push
);

	logic [skbh_pkg::CrcW-1:0] crc_q;
	logic [skbh_pkg::CrcW-1:0] crc_nx;
	logic acc;

	assign key.ready = !q_full;
	assign acc = key.valid && key.ready;
	assign crc_nx = key.byte_present ? skbh_pkg::crc_byte(crc_q, key.key_byte) : crc_q;

	assign push.valid = acc && key.last_byte;
	assign push.crc = crc_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (acc) begin
			crc_q <= key.last_byte ? '0 : crc_nx;
		end
	end

endmodule
`default_nettype wire

// File: design/skbh_queue.sv
`default_nettype none
module skbh_queue #(
	parameter int unsigned Depth = skbh_pkg::QueueDepthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire skbh_pkg::crc_push_t push,
	output logic full,
	output logic pop_valid,
	input wire logic pop_ready,
	output logic [skbh_pkg::CrcW-1:0] pop_crc
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	logic [skbh_pkg::CrcW-1:0] mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == FullCnt);
	assign pop_valid = (cnt_q != '0);
	assign pop_crc = mem_q[rd_q];
	assign do_push = push.valid && !full;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.crc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FullCnt)
		else $error("queue count overflow");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n) push.valid |-> !full)
		else $error("transaction pushed into full queue");

endmodule
`default_nettype wire

// File: design/skbh_back.sv
`default_nettype none
module skbh_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire logic [skbh_pkg::CrcW-1:0] q_crc,
	input wire logic [skbh_pkg::SizeW-1:0] table_size,
	skbh_bucket_if.source bucket
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIX,
		S_MUL_LO,
		S_MUL_HI,
		S_SUM,
		S_DIV,
		S_DONE
	} state_t;

	localparam int unsigned HashW = skbh_pkg::HashW;
	localparam int unsigned SizeW = skbh_pkg::SizeW;
	localparam logic [2:0] LastMix = 3'(skbh_pkg::MixSteps - 1);
	localparam logic [5:0] LastBit = 6'(HashW - 1);

	state_t state_q;
	logic [2:0] step_q;
	logic [5:0] cnt_q;
	logic [HashW-1:0] k_q;
	logic [HashW-1:0] lo_q;
	logic [31:0] hi_q;
	logic [HashW-1:0] dvd_q;
	logic [SizeW-1:0] rem_q;
	logic [SizeW-1:0] tsz_q;
	logic [skbh_pkg::IndexW-1:0] out_q;

	logic [HashW-1:0] lo_prod;
	logic [31:0] hi_prod;
	logic [SizeW:0] r2;
	logic ge;
	logic [SizeW-1:0] rem_nx;

	function automatic logic [HashW-1:0] mix_step(input logic [HashW-1:0] k,
			input logic [2:0] s);
		logic [HashW-1:0] r;
		case (s)
			3'd0: r = k + (k << 12);
			3'd1: r = k ^ (k >> 22);
			3'd2: r = k + (k << 4);
			3'd3: r = k ^ (k >> 9);
			3'd4: r = k + (k << 10);
			3'd5: r = k ^ (k >> 2);
			3'd6: r = k + (k << 7);
			default: r = k ^ (k >> 12);
		endcase
		return r;
	endfunction

	// (k >> 3) * mult mod 2^64 split into two 32x32 products
	assign lo_prod = 64'(k_q[34:3]) * 64'(skbh_pkg::KnuthMult);
	assign hi_prod = {3'b0, k_q[63:35]} * skbh_pkg::KnuthMult;

	assign r2 = {rem_q, dvd_q[HashW-1]};
	assign ge = (r2 >= {1'b0, tsz_q});
	assign rem_nx = ge ? SizeW'(r2 - {1'b0, tsz_q}) : r2[SizeW-1:0];

	assign q_ready = (state_q == S_IDLE);
	assign bucket.valid = (state_q == S_DONE);
	assign bucket.bucket_index = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						k_q <= {{(HashW-skbh_pkg::CrcW){1'b0}}, q_crc};
						step_q <= '0;
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					k_q <= mix_step(k_q, step_q);
					step_q <= step_q + 1'b1;
					if (step_q == LastMix) begin
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: begin
					lo_q <= lo_prod;
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					hi_q <= hi_prod;
					state_q <= S_SUM;
				end
				S_SUM: begin
					dvd_q <= lo_q + {hi_q, 32'b0};
					rem_q <= '0;
					cnt_q <= '0;
					tsz_q <= table_size;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_nx;
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastBit) begin
						out_q <= (tsz_q == '0) ? '0 : rem_nx[skbh_pkg::IndexW-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (bucket.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rem_lt_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && tsz_q != '0) |-> (rem_q < tsz_q))
		else $error("partial remainder not below divisor");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |=> (state_q == S_DIV && cnt_q == '0))
		else $error("divide did not start clean");
	a_done_leave: assert property (@(posedge clk) disable iff (!arst_n)
		(bucket.valid && bucket.ready) |=> (state_q == S_IDLE))
		else $error("result transaction not retired");

endmodule
`default_nettype wire

// File: design/string_key_bucket_hasher.sv
// channel      | role | payload                                 | handshake
// key          | in   | key_byte[7:0], byte_present, last_byte  | valid/ready
// bucket       | out  | bucket_index[29:0]                      | valid/ready
// table_size   | cfg  | table_size_wdata[30:0]                  | table_size_we
//
// Key bytes are taken one per cycle while the queue is not full; each CRC update is a
// single table-entry computation. The back end takes a CRC only when idle, mixes it in
// eight steps, multiplies, sums, then runs the one-bit-per-cycle remainder loop.
// A QueueDepth-entry queue holds finished CRCs; key.ready drops only while it is full.
// arst_n clears the CRC, queue and sequencer; table_size resets to 256.
`default_nettype none
module string_key_bucket_hasher #(
	parameter int unsigned QueueDepth = skbh_pkg::QueueDepthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	skbh_key_if.sink key,
	skbh_bucket_if.source bucket,
	input wire logic table_size_we,
	input wire logic [skbh_pkg::SizeW-1:0] table_size_wdata
);

	logic [skbh_pkg::SizeW-1:0] table_size_q;
	skbh_pkg::crc_push_t push;
	logic q_full;
	logic q_valid;
	logic q_ready;
	logic [skbh_pkg::CrcW-1:0] q_crc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= skbh_pkg::TableSizeReset;
		end else if (table_size_we) begin
			table_size_q <= table_size_wdata;
		end
	end

	skbh_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.key(key),
		.q_full(q_full),
		.push(push)
	);

	skbh_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(q_full),
		.pop_valid(q_valid),
		.pop_ready(q_ready),
		.pop_crc(q_crc)
	);

	skbh_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_crc(q_crc),
		.table_size(table_size_q),
		.bucket(bucket)
	);

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned ByteW = skbh_pkg::ByteW;
	localparam int unsigned CrcW = skbh_pkg::CrcW;
	localparam int unsigned SizeW = skbh_pkg::SizeW;
	localparam int unsigned IndexW = skbh_pkg::IndexW;
	localparam logic [SizeW-1:0] TableSizeReset = skbh_pkg::TableSizeReset;

	localparam int unsigned IdleLimit = 3000;
	localparam int unsigned DrainCycles = 100;

	logic clk;
	logic arst_n;
	logic table_size_we;
	logic [SizeW-1:0] table_size_wdata;

	skbh_key_if key_ch();
	skbh_bucket_if bucket_ch();

	string_key_bucket_hasher DUT (
		.clk(clk),
		.arst_n(arst_n),
		.key(key_ch),
		.bucket(bucket_ch),
		.table_size_we(table_size_we),
		.table_size_wdata(table_size_wdata)
	);

	logic [CrcW-1:0] running_crc;
	logic [SizeW-1:0] cur_table_size;
	logic [IndexW-1:0] expected_buckets[$];
	int mismatches;
	int bytes_sent;
	int keys_sent;
	int buckets_checked;
	int sizes_tried;
	int src_idle_pct;
	int sink_idle_pct;
	int sink_stall_left;
	int idle_cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [CrcW-1:0] crc_of_byte(input logic [CrcW-1:0] crc,
			input logic [ByteW-1:0] b);
		logic [CrcW-1:0] v;
		v = {24'b0, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			if (v[0])
				v = (v >> 1) ^ 32'hEDB88320;
			else
				v = v >> 1;
		end
		return v ^ (crc >> 8);
	endfunction

	function automatic logic [IndexW-1:0] bucket_of_crc(input logic [CrcW-1:0] crc);
		logic [63:0] k;
		logic [63:0] h;
		logic [63:0] r;
		k = {32'b0, crc};
		k = k + (k << 12);
		k = k ^ (k >> 22);
		k = k + (k << 4);
		k = k ^ (k >> 9);
		k = k + (k << 10);
		k = k ^ (k >> 2);
		k = k + (k << 7);
		k = k ^ (k >> 12);
		h = (k >> 3) * 64'd2654435761;
		if (cur_table_size == '0)
			return '0;
		r = h % {33'b0, cur_table_size};
		return r[IndexW-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		logic [IndexW-1:0] want;
		if (arst_n && bucket_ch.valid && bucket_ch.ready) begin
			if (expected_buckets.size() == 0) begin
				report_mismatch($sformatf("unexpected bucket_index %0d", bucket_ch.bucket_index));
			end else begin
				want = expected_buckets.pop_front();
				buckets_checked++;
				if (bucket_ch.bucket_index !== want)
					report_mismatch($sformatf("bucket_index %0d, expected %0d (table_size %0d)",
						bucket_ch.bucket_index, want, cur_table_size));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (key_ch.valid && key_ch.ready) ||
				(bucket_ch.valid && bucket_ch.ready) || table_size_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("timeout: no transaction for %0d cycles", IdleLimit);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		bucket_ch.ready = 1'b0;
		sink_stall_left = 0;
		forever begin
			@(negedge clk);
			if (sink_stall_left > 0) begin
				bucket_ch.ready <= 1'b0;
				sink_stall_left--;
			end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
				bucket_ch.ready <= 1'b0;
				sink_stall_left = $urandom_range(3, 0);
			end else begin
				bucket_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_step(input logic [ByteW-1:0] b, input logic present, input logic last);
		int gap;
		@(negedge clk);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			gap = $urandom_range(4, 1);
			key_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		key_ch.valid <= 1'b1;
		key_ch.key_byte <= b;
		key_ch.byte_present <= present;
		key_ch.last_byte <= last;
		do @(posedge clk); while (!key_ch.ready);
		if (present) begin
			running_crc = crc_of_byte(running_crc, b);
			bytes_sent++;
		end
		if (last) begin
			expected_buckets.push_back(bucket_of_crc(running_crc));
			running_crc = '0;
			keys_sent++;
		end
	endtask

	task automatic drain;
		@(negedge clk);
		key_ch.valid <= 1'b0;
		while (expected_buckets.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_table_size(input logic [SizeW-1:0] size);
		drain();
		@(negedge clk);
		table_size_we <= 1'b1;
		table_size_wdata <= size;
		@(posedge clk);
		cur_table_size = size;
		sizes_tried++;
		@(negedge clk);
		table_size_we <= 1'b0;
	endtask

	task automatic send_random_key;
		int len;
		int kind;
		bit open_end;
		kind = $urandom_range(99);
		if (kind < 6)
			len = 0;
		else if (kind < 12)
			len = $urandom_range(40, 16);
		else
			len = $urandom_range(8, 1);
		open_end = ($urandom_range(9) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(15) == 0)
				send_step($urandom_range(255), 1'b0, 1'b0);
			send_step($urandom_range(255), 1'b1, (i == len - 1) && !open_end);
		end
		if (len == 0 || open_end)
			send_step($urandom_range(255), 1'b0, 1'b1);
	endtask

	task automatic test_random_keys(input int n_bytes);
		int stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_key();
	endtask

	task automatic test_special_keys;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		send_step(8'h00, 1'b0, 1'b1);
		send_step(8'hA5, 1'b0, 1'b0);
		send_step(8'h5A, 1'b0, 1'b1);
		send_step(8'h00, 1'b1, 1'b1);
		send_step(8'hFF, 1'b1, 1'b1);
		send_step(8'h00, 1'b1, 1'b0);
		send_step(8'h00, 1'b1, 1'b0);
		send_step(8'h41, 1'b1, 1'b1);
		send_step(8'hFF, 1'b1, 1'b0);
		send_step(8'h3C, 1'b0, 1'b0);
		send_step(8'hFF, 1'b1, 1'b0);
		send_step(8'hC3, 1'b0, 1'b1);
		send_step(8'h61, 1'b1, 1'b0);
		send_step(8'h62, 1'b1, 1'b0);
		send_step(8'h63, 1'b1, 1'b1);
		send_step(8'h80, 1'b1, 1'b0);
		send_step(8'h01, 1'b1, 1'b1);
		send_step(8'h00, 1'b0, 1'b1);
		send_step(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_table_size_extremes;
		logic [SizeW-1:0] sizes[7];
		sizes[0] = 31'd1;
		sizes[1] = 31'd0;
		sizes[2] = 31'h4000_0000;
		sizes[3] = 31'h7FFF_FFFF;
		sizes[4] = 31'h4000_0001;
		sizes[5] = SizeW'($urandom_range(32'h4000_0000, 2));
		sizes[6] = 31'd1021;
		foreach (sizes[i]) begin
			write_table_size(sizes[i]);
			case (i % 4)
				0: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
				1: begin
					src_idle_pct = 25;
					sink_idle_pct = 25;
				end
				2: begin
					src_idle_pct = 50;
					sink_idle_pct = 10;
				end
				default: begin
					src_idle_pct = 10;
					sink_idle_pct = 60;
				end
			endcase
			test_random_keys(160);
		end
	endtask

	task automatic test_back_to_back_tail;
		write_table_size(TableSizeReset);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_keys(150);
	endtask

	initial begin
		arst_n = 1'b0;
		table_size_we = 1'b0;
		table_size_wdata = '0;
		key_ch.valid = 1'b0;
		key_ch.key_byte = '0;
		key_ch.byte_present = 1'b0;
		key_ch.last_byte = 1'b0;
		running_crc = '0;
		cur_table_size = TableSizeReset;
		mismatches = 0;
		bytes_sent = 0;
		keys_sent = 0;
		buckets_checked = 0;
		sizes_tried = 0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		idle_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_special_keys();
		test_table_size_extremes();
		test_back_to_back_tail();

		drain();
		$display("covered %0d key bytes in %0d keys, %0d bucket indexes compared",
			bytes_sent, keys_sent, buckets_checked);
		$display("over %0d table sizes incl. 0, 1, 2^30 and the 31-bit maximum", sizes_tried);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
